FILE: src/ell_pkg.sv
package ell_pkg;

    localparam int ELL_MAX_TOKEN_LEN = 32;
    // Wide enough for any value length up to 63
    localparam int ELL_LEN_W = 6;
    localparam int ELL_CMDQ_DEPTH = 2;
    localparam int ELL_PRINT_LEN = 5;

    typedef logic [3:0] t_kind;

    localparam t_kind KIND_NUMBER       = 4'd0;
    localparam t_kind KIND_TEXT         = 4'd1;
    localparam t_kind KIND_WORD         = 4'd2;
    localparam t_kind KIND_PRINT        = 4'd3;
    localparam t_kind KIND_PLUS         = 4'd4;
    localparam t_kind KIND_MINUS        = 4'd5;
    localparam t_kind KIND_STAR         = 4'd6;
    localparam t_kind KIND_SLASH        = 4'd7;
    localparam t_kind KIND_LPAREN       = 4'd8;
    localparam t_kind KIND_RPAREN       = 4'd9;
    localparam t_kind KIND_EQUAL        = 4'd10;
    localparam t_kind KIND_NEWLINE      = 4'd11;
    localparam t_kind KIND_EOF          = 4'd12;
    localparam t_kind KIND_UNTERMINATED = 4'd13;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NL      = 8'h0a;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_USCORE  = 8'h5f;

    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        t_kind      token_kind;
        logic [7:0] value_char;
        logic       char_valid;
        logic       token_last;
        logic       value_truncated;
    } t_result;

    // One token, handed from the front to the back. len counts the characters
    // that the token left in the character store; emit_value clear means
    // "give one empty result and drop those characters".
    typedef struct packed {
        t_kind                kind;
        logic [ELL_LEN_W-1:0] len;
        logic                 truncated;
        logic                 emit_value;
    } t_cmd;

    typedef struct packed {
        logic       wr;
        logic [7:0] data;
    } t_char_wr;

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_NUMBER = 4'b0010,
        MODE_TEXT   = 4'b0100,
        MODE_WORD   = 4'b1000
    } t_mode;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || (c == CH_USCORE);
    endfunction

    function automatic logic [7:0] print_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h70;
            3'd1:    c = 8'h72;
            3'd2:    c = 8'h69;
            3'd3:    c = 8'h6e;
            3'd4:    c = 8'h74;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // {hit, kind} for the single-character operators
    function automatic logic [4:0] op_lookup(input logic [7:0] c);
        logic [4:0] r;
        case (c)
            8'h2b:   r = {1'b1, KIND_PLUS};
            8'h2d:   r = {1'b1, KIND_MINUS};
            8'h2a:   r = {1'b1, KIND_STAR};
            8'h2f:   r = {1'b1, KIND_SLASH};
            8'h28:   r = {1'b1, KIND_LPAREN};
            8'h29:   r = {1'b1, KIND_RPAREN};
            8'h3d:   r = {1'b1, KIND_EQUAL};
            default: r = {1'b0, KIND_NUMBER};
        endcase
        return r;
    endfunction

    // Close the open token of the given mode
    function automatic t_cmd finish_cmd(input t_mode m, input logic [ELL_LEN_W-1:0] len,
                                        input logic ovf, input logic pmatch);
        t_cmd c;
        c.kind       = KIND_NUMBER;
        c.len        = len;
        c.truncated  = ovf;
        c.emit_value = 1'b1;
        case (m)
            MODE_WORD: begin
                if (pmatch && !ovf && (len == ELL_LEN_W'(ELL_PRINT_LEN))) begin
                    c.kind       = KIND_PRINT;
                    c.emit_value = 1'b0;
                end else begin
                    c.kind = KIND_WORD;
                end
            end
            MODE_TEXT: begin
                c.kind       = KIND_UNTERMINATED;
                c.emit_value = 1'b0;
            end
            default: ;
        endcase
        return c;
    endfunction

endpackage

FILE: src/ell_front.sv
module ell_front #(
    parameter int MAX_TOKEN_LEN = ell_pkg::ELL_MAX_TOKEN_LEN
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ell_pkg::t_in_item i_item,
    input  logic              i_push,
    output logic              o_full,
    input  logic              i_chars_full,
    output ell_pkg::t_char_wr o_char_wr,
    output ell_pkg::t_cmd     o_cmd,
    output logic              o_cmd_push,
    input  logic              i_cmd_full
);
    import ell_pkg::*;

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam int SLOTS = 4;
    localparam int SEL_W = $clog2(SLOTS);

    t_mode              r_mode, n_mode;
    logic [LEN_W-1:0]   r_len, n_len;
    logic               r_ovf, n_ovf;
    logic               r_pmatch, n_pmatch;
    logic [SLOTS-1:0]   r_pend_vld, n_pend_vld;
    t_cmd               r_pend [SLOTS];
    t_cmd               n_pend [SLOTS];

    logic               accept;
    logic [SEL_W-1:0]   sel;
    logic               wr_char;

    assign o_full = (|r_pend_vld) || i_chars_full;
    assign accept = i_push && !o_full;

    always_comb begin
        sel = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_pend_vld[i]) sel = SEL_W'(i);
        end
    end

    assign o_cmd      = r_pend[sel];
    assign o_cmd_push = (|r_pend_vld) && !i_cmd_full;

    // Lex one item: at most one finished token, one single-character token,
    // then on end of input one more finished token and the end-of-file token
    always_comb begin
        logic [7:0] c;
        logic       done;
        logic       app;
        logic [4:0] op;
        t_cmd       cand [SLOTS];
        logic [SLOTS-1:0] cvld;

        c        = i_item.char_code;
        done     = 1'b0;
        app      = 1'b0;
        op       = op_lookup(c);
        cvld     = '0;
        for (int i = 0; i < SLOTS; i++) begin
            cand[i] = finish_cmd(MODE_IDLE, '0, 1'b0, 1'b0);
        end
        n_mode   = r_mode;
        n_len    = r_len;
        n_ovf    = r_ovf;
        n_pmatch = r_pmatch;
        wr_char  = 1'b0;

        if (i_item.has_char) begin
            case (r_mode)
                MODE_TEXT: begin
                    done = 1'b1;
                    if (c == CH_QUOTE) begin
                        cand[0] = '{kind: KIND_TEXT, len: ELL_LEN_W'(r_len),
                                    truncated: r_ovf, emit_value: 1'b1};
                        cvld[0] = 1'b1;
                        n_mode  = MODE_IDLE;
                        n_len   = '0;
                        n_ovf   = 1'b0;
                    end else if (c == CH_NUL) begin
                        cand[0] = finish_cmd(r_mode, ELL_LEN_W'(r_len), r_ovf, r_pmatch);
                        cvld[0] = 1'b1;
                        n_mode  = MODE_IDLE;
                        n_len   = '0;
                        n_ovf   = 1'b0;
                    end else begin
                        app = 1'b1;
                    end
                end
                MODE_NUMBER, MODE_WORD: begin
                    if ((r_mode == MODE_NUMBER) ? is_digit(c) : is_ident(c)) begin
                        app  = 1'b1;
                        done = 1'b1;
                    end else begin
                        cand[0] = finish_cmd(r_mode, ELL_LEN_W'(r_len), r_ovf, r_pmatch);
                        cvld[0] = 1'b1;
                        n_mode  = MODE_IDLE;
                        n_len   = '0;
                        n_ovf   = 1'b0;
                    end
                end
                default: ;
            endcase

            // A byte that closed a number or word is lexed afresh from idle
            if (!done) begin
                if (is_digit(c)) begin
                    n_mode = MODE_NUMBER;
                    n_len  = '0;
                    n_ovf  = 1'b0;
                    app    = 1'b1;
                end else if (c == CH_QUOTE) begin
                    n_mode = MODE_TEXT;
                    n_len  = '0;
                    n_ovf  = 1'b0;
                end else if (is_letter(c)) begin
                    n_mode = MODE_WORD;
                    n_len  = '0;
                    n_ovf  = 1'b0;
                    app    = 1'b1;
                end else if (c == CH_NL) begin
                    cand[1] = '{kind: KIND_NEWLINE, len: '0, truncated: 1'b0,
                                emit_value: 1'b0};
                    cvld[1] = 1'b1;
                end else if (op[4]) begin
                    cand[1] = '{kind: op[3:0], len: '0, truncated: 1'b0, emit_value: 1'b0};
                    cvld[1] = 1'b1;
                end
            end

            // Buffer the character, or flag the overflow
            if (app) begin
                if (n_len < LEN_W'(MAX_TOKEN_LEN)) begin
                    wr_char = 1'b1;
                    if (n_len == '0) begin
                        n_pmatch = (c == print_char(3'd0));
                    end else begin
                        n_pmatch = n_pmatch && (n_len < LEN_W'(ELL_PRINT_LEN))
                                   && (c == print_char(n_len[2:0]));
                    end
                    n_len = n_len + LEN_W'(1);
                end else begin
                    n_ovf = 1'b1;
                end
            end
        end

        if (i_item.end_of_input) begin
            cand[2] = finish_cmd(n_mode, ELL_LEN_W'(n_len), n_ovf, n_pmatch);
            cvld[2] = (n_mode != MODE_IDLE);
            cand[3] = '{kind: KIND_EOF, len: '0, truncated: 1'b0, emit_value: 1'b0};
            cvld[3] = 1'b1;
            n_mode  = MODE_IDLE;
            n_len   = '0;
            n_ovf   = 1'b0;
        end

        // Hold pending tokens until the queue takes them, lowest slot first
        n_pend_vld = r_pend_vld;
        for (int i = 0; i < SLOTS; i++) begin
            n_pend[i] = r_pend[i];
        end
        if (accept) begin
            n_pend_vld = cvld;
            for (int i = 0; i < SLOTS; i++) begin
                n_pend[i] = cand[i];
            end
        end else if (o_cmd_push) begin
            n_pend_vld[sel] = 1'b0;
        end

        if (!accept) begin
            n_mode   = r_mode;
            n_len    = r_len;
            n_ovf    = r_ovf;
            n_pmatch = r_pmatch;
            wr_char  = 1'b0;
        end
    end

    assign o_char_wr.wr   = wr_char;
    assign o_char_wr.data = i_item.char_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_len      <= '0;
            r_ovf      <= 1'b0;
            r_pmatch   <= 1'b0;
            r_pend_vld <= '0;
        end else begin
            r_mode     <= n_mode;
            r_len      <= n_len;
            r_ovf      <= n_ovf;
            r_pmatch   <= n_pmatch;
            r_pend_vld <= n_pend_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SLOTS; i++) begin
            r_pend[i] <= n_pend[i];
        end
    end

endmodule

FILE: src/ell_cmdq.sv
module ell_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ell_pkg::t_cmd i_cmd,
    input  logic          i_push,
    output logic          o_full,
    output ell_pkg::t_cmd o_cmd,
    input  logic          i_pop,
    output logic          o_empty
);
    import ell_pkg::*;

    localparam int AW = $clog2(ELL_CMDQ_DEPTH);

    t_cmd        r_q [ELL_CMDQ_DEPTH];
    logic [AW:0] r_wp, r_rp;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[AW] != r_rp[AW]) && (r_wp[AW-1:0] == r_rp[AW-1:0]);
    assign o_cmd   = r_q[r_rp[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= r_wp + (AW + 1)'(1);
            if (i_pop && !o_empty) r_rp <= r_rp + (AW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_q[r_wp[AW-1:0]] <= i_cmd;
    end

endmodule

FILE: src/ell_back.sv
module ell_back #(
    parameter int MAX_TOKEN_LEN = ell_pkg::ELL_MAX_TOKEN_LEN
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ell_pkg::t_char_wr i_char_wr,
    output logic              o_chars_full,
    input  ell_pkg::t_cmd     i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    output ell_pkg::t_result  o_result,
    output logic              o_empty,
    input  logic              i_pop
);
    import ell_pkg::*;

    // Room for one token being built plus at least one finished one
    localparam int DEPTH = 2 ** $clog2(2 * MAX_TOKEN_LEN);
    localparam int AW    = $clog2(DEPTH);

    logic [7:0]           r_mem [DEPTH];
    logic [7:0]           r_rdata;
    logic [AW:0]          r_wp;
    logic [AW:0]          r_rp, n_rp;

    logic                 r_busy, n_busy;
    t_kind                r_kind, n_kind;
    logic [ELL_LEN_W-1:0] r_left, n_left;
    logic                 r_trunc, n_trunc;
    logic                 r_rd_pend, n_rd_pend;
    logic                 r_rd_last, n_rd_last;
    logic                 r_out_valid, n_out_valid;
    t_result              r_out, n_out;

    logic                 out_take;
    logic                 can_issue;
    logic                 rd_en;
    logic                 cmd_has_value;

    assign o_chars_full = (r_wp[AW] != r_rp[AW]) && (r_wp[AW-1:0] == r_rp[AW-1:0]);
    assign o_result     = r_out;
    assign o_empty      = !r_out_valid;

    assign out_take      = r_out_valid && i_pop;
    // Issue only when the output register is sure to be free next cycle
    assign can_issue     = !r_rd_pend && (!r_out_valid || out_take);
    assign rd_en         = can_issue && r_busy;
    assign o_cmd_pop     = can_issue && !r_busy && !i_cmd_empty;
    assign cmd_has_value = i_cmd.emit_value && (i_cmd.len != '0);

    always_comb begin
        n_rp        = r_rp;
        n_busy      = r_busy;
        n_kind      = r_kind;
        n_left      = r_left;
        n_trunc     = r_trunc;
        n_rd_pend   = 1'b0;
        n_rd_last   = r_rd_last;
        n_out_valid = r_out_valid && !out_take;
        n_out       = r_out;

        if (r_rd_pend) begin
            n_out_valid = 1'b1;
            n_out = '{token_kind: r_kind, value_char: r_rdata, char_valid: 1'b1,
                      token_last: r_rd_last, value_truncated: r_trunc};
        end

        if (rd_en) begin
            n_rp      = r_rp + (AW + 1)'(1);
            n_left    = r_left - ELL_LEN_W'(1);
            n_rd_pend = 1'b1;
            n_rd_last = (r_left == ELL_LEN_W'(1));
            n_busy    = (r_left != ELL_LEN_W'(1));
        end else if (o_cmd_pop) begin
            if (cmd_has_value) begin
                n_busy  = 1'b1;
                n_kind  = i_cmd.kind;
                n_left  = i_cmd.len;
                n_trunc = i_cmd.truncated;
            end else begin
                // Empty-valued token: one result, drop whatever it buffered
                n_rp        = r_rp + (AW + 1)'(i_cmd.len);
                n_out_valid = 1'b1;
                n_out = '{token_kind: i_cmd.kind, value_char: 8'h00, char_valid: 1'b0,
                          token_last: 1'b1, value_truncated: 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_busy      <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_char_wr.wr) r_wp <= r_wp + (AW + 1)'(1);
            r_rp        <= n_rp;
            r_busy      <= n_busy;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_left    <= n_left;
        r_trunc   <= n_trunc;
        r_rd_last <= n_rd_last;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (i_char_wr.wr) r_mem[r_wp[AW-1:0]] <= i_char_wr.data;
        if (rd_en) r_rdata <= r_mem[r_rp[AW-1:0]];
    end

endmodule

FILE: src/expression_language_lexer_unit.sv
// Flow: an item that posts tokens holds full until the command queue has taken every token
//   it posts. Through the single read port of the character store, the back reads each value
//   character and registers it into the output stage before it reads the next one, and it
//   pops each token's transaction from the queue before that token's first read.
// Reset (synchronous, active low): lexer idle, all queues empty, no result shown;
//   the character store itself is not cleared.
module expression_language_lexer_unit #(
    parameter int MAX_TOKEN_LEN = ell_pkg::ELL_MAX_TOKEN_LEN
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ell_pkg::t_in_item i_in,
    input  logic              push,
    output logic              full,
    output ell_pkg::t_result  o_result,
    output logic              empty,
    input  logic              pop
);
    import ell_pkg::*;

    // Front: classify each byte, track the lexer mode and the open token's length,
    // write token characters into the store and post one transaction per token.
    // Back: take token transactions in order and stream their characters out.
    t_char_wr char_wr;
    logic     chars_full;
    t_cmd     front_cmd;
    logic     front_push;
    logic     cmdq_full;
    t_cmd     back_cmd;
    logic     back_pop;
    logic     cmdq_empty;

    ell_front #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_in),
        .i_push       (push),
        .o_full       (full),
        .i_chars_full (chars_full),
        .o_char_wr    (char_wr),
        .o_cmd        (front_cmd),
        .o_cmd_push   (front_push),
        .i_cmd_full   (cmdq_full)
    );

    // Short queue so that the front can close a token while the back still streams
    ell_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (front_cmd),
        .i_push  (front_push),
        .o_full  (cmdq_full),
        .o_cmd   (back_cmd),
        .i_pop   (back_pop),
        .o_empty (cmdq_empty)
    );

    ell_back #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_wr    (char_wr),
        .o_chars_full (chars_full),
        .i_cmd        (back_cmd),
        .i_cmd_empty  (cmdq_empty),
        .o_cmd_pop    (back_pop),
        .o_result     (o_result),
        .o_empty      (empty),
        .i_pop        (pop)
    );

endmodule
